// ----- rtl/cpc_pkg.sv -----
package cpc_pkg;

    localparam int MAX_PACKET_BYTES = 20;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int NEED_W           = 6;
    localparam int QUOT_W           = 8;
    localparam int DIV_CNT_W        = $clog2(QUOT_W);

    localparam logic [7:0] FLAG_BALANCE = 8'h01;
    localparam logic [7:0] FLAG_TORQUE  = 8'h04;
    localparam logic [7:0] FLAG_WHEEL   = 8'h10;
    localparam logic [7:0] FLAG_CRANK   = 8'h20;

    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    localparam int          CFG_IDX_W          = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIVE_CADENCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_TIMEOUT  = 1'd1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [15:0] power_watts;
        logic [7:0]  cadence_rpm;
        logic [31:0] revolutions;
        logic [15:0] event_time;
        logic        revs_present;
        logic        packet_error;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_CHECK,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        CAD_KEEP,
        CAD_STALE,
        CAD_REJECT,
        CAD_NEW
    } cad_mode_t;

    typedef struct packed {
        logic      take_byte;
        logic      load_diff;
        logic      load_mul;
        logic      div_start;
        logic      div_step;
        logic      commit;
        cad_mode_t cad_mode;
    } cmd_t;

    typedef struct packed {
        logic pkt_error;
        logic has_revs;
        logic derive;
        logic need_div;
        logic fits;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/cycling_power_packet_cadence_top.sv -----
// Cycling power measurement parser. Packet bytes arrive one per transfer; bytes that are
// not the last of their packet are accepted back to back. The last byte yields one result:
// a subtract stage forms the differences; when no new cadence is formed the result follows
// it directly, otherwise a multiply-by-15 stage and a range check follow, and when the
// quotient fits in 8 bits an eight-step restoring divider forms the 8-bit cadence quotient.
// The final cycle of an evaluation is held while an earlier result still waits unaccepted
// in the output register. A finished result waits there while the next packet streams in.
// Configuration writes are always ready.
module cycling_power_packet_cadence_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cpc_pkg::in_t                  s_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output cpc_pkg::out_t                 m_payload,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);
    import cpc_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    cpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_payload.last_byte),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cpc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_item   (s_payload),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

`ifndef SYNTHESIS
    // The block is busy right after the last byte of a packet.
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.last_byte |=> !s_ready)
        else $error("input taken during packet evaluation");

    // A new result only appears after the input was held not ready for evaluation.
    a_result_from_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !$past(m_valid) |-> !$past(s_ready))
        else $error("result appeared without packet evaluation");

    // An errored packet reports no packet fields.
    a_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.packet_error |->
            !m_payload.revs_present && m_payload.power_watts == 16'd0)
        else $error("errored packet carries fields");
`endif

endmodule

// ----- rtl/cpc_ctrl.sv -----
module cpc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_last,
    output logic             s_ready,
    input  cpc_pkg::status_t status,
    output cpc_pkg::cmd_t    cmd
);
    import cpc_pkg::*;

    state_t                 state_reg, state_next;
    cad_mode_t              mode_reg, mode_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= CAD_KEEP;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_last) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (status.pkt_error || !status.has_revs || !status.derive) begin
                    mode_next  = CAD_KEEP;
                    state_next = ST_DONE;
                end else if (!status.need_div) begin
                    mode_next  = CAD_STALE;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!status.fits) begin
                    mode_next  = CAD_REJECT;
                    state_next = ST_DONE;
                end else begin
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(QUOT_W - 1)) begin
                    mode_next  = CAD_NEW;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.cad_mode = mode_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.take_byte = s_valid;
            end
            ST_EVAL: begin
                cmd.load_diff = 1'b1;
            end
            ST_MUL: begin
                cmd.load_mul = 1'b1;
            end
            ST_CHECK: begin
                cmd.div_start = status.fits;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            ST_DONE: begin
                cmd.commit = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/cpc_datapath.sv -----
module cpc_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cpc_pkg::in_t                      in_item,
    input  cpc_pkg::cmd_t                     cmd,
    output cpc_pkg::status_t                  status,
    input  logic                              cfg_valid,
    input  logic [cpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                       cfg_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output cpc_pkg::out_t                     m_payload
);
    import cpc_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_inc, len_reg;
    logic [7:0]        flags_reg;
    logic [15:0]       power_reg;
    logic [31:0]       rev_reg;
    logic [15:0]       time_reg;
    logic [31:0]       now_reg;
    logic [31:0]       prev_revs_reg;
    logic [15:0]       prev_time_reg;
    logic [7:0]        cadence_reg, cadence_next;
    logic [31:0]       last_good_reg;
    logic              derive_reg;
    logic [15:0]       timeout_reg;
    logic [31:0]       dr_reg;
    logic [15:0]       dt_reg;
    logic [35:0]       prod_reg;
    logic [15:0]       rem_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic              m_valid_reg;
    out_t              out_reg;

    logic              has_bal, has_torq, has_wheel, has_crank, has_revs;
    logic [NEED_W-1:0] data_off, rev_start, pos_ext, idx, needed;
    logic              in_range, pkt_error, stale;
    logic [16:0]       rem2;
    logic              ge;

    assign has_bal   = (flags_reg & FLAG_BALANCE) != '0;
    assign has_torq  = (flags_reg & FLAG_TORQUE) != '0;
    assign has_wheel = (flags_reg & FLAG_WHEEL) != '0;
    assign has_crank = (flags_reg & FLAG_CRANK) != '0;
    assign has_revs  = has_wheel || has_crank;

    assign pos_inc = (pos_reg < POS_W'(MAX_PACKET_BYTES)) ? pos_reg + 1'b1 : pos_reg;

    // Wheel data comes first when both blocks are flagged, and is then skipped.
    assign data_off  = NEED_W'(4) + (has_bal ? NEED_W'(1) : '0) + (has_torq ? NEED_W'(2) : '0);
    assign rev_start = data_off + ((has_crank && has_wheel) ? NEED_W'(6) : '0);
    assign pos_ext   = NEED_W'(pos_reg);
    assign in_range  = pos_ext >= rev_start;
    assign idx       = pos_ext - rev_start;

    always_comb begin
        if (has_crank) begin
            needed = rev_start + NEED_W'(4);
        end else if (has_wheel) begin
            needed = data_off + NEED_W'(6);
        end else begin
            needed = NEED_W'(4);
        end
    end

    assign pkt_error = NEED_W'(len_reg) < needed;

    assign stale = (now_reg - last_good_reg) > {16'd0, timeout_reg};

    // One restoring step; the remainder always stays below the divisor.
    assign rem2 = {rem_reg, 1'b0};
    assign ge   = rem2 >= {1'b0, dt_reg};

    assign status.pkt_error = pkt_error;
    assign status.has_revs  = has_revs;
    assign status.derive    = derive_reg;
    assign status.need_div  = (rev_reg != prev_revs_reg) && (time_reg != prev_time_reg);
    assign status.fits      = (prod_reg[35:12] == '0) && ({prod_reg[11:0], 4'd0} < dt_reg);
    assign status.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        cadence_next = cadence_reg;
        case (cmd.cad_mode)
            CAD_KEEP:   cadence_next = cadence_reg;
            CAD_STALE:  cadence_next = stale ? 8'd0 : cadence_reg;
            CAD_REJECT: cadence_next = cadence_reg;
            CAD_NEW:    cadence_next = quot_reg;
            default:    cadence_next = cadence_reg;
        endcase
    end

    // Control state and the state carried from packet to packet.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            derive_reg    <= 1'b1;
            timeout_reg   <= TIMEOUT_RESET;
            prev_revs_reg <= '0;
            prev_time_reg <= '0;
            cadence_reg   <= '0;
            last_good_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.take_byte) begin
                pos_reg <= in_item.last_byte ? '0 : pos_inc;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    REG_DERIVE_CADENCE: derive_reg  <= cfg_data[0];
                    REG_STALE_TIMEOUT:  timeout_reg <= cfg_data;
                    default:            derive_reg  <= derive_reg;
                endcase
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
                if (!pkt_error) begin
                    cadence_reg <= cadence_next;
                    if (has_revs) begin
                        prev_revs_reg <= rev_reg;
                        prev_time_reg <= time_reg;
                    end
                    if (cmd.cad_mode == CAD_NEW || cmd.cad_mode == CAD_REJECT) begin
                        last_good_reg <= now_reg;
                    end
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Packet fields, arithmetic and the result register.
    always_ff @(posedge aclk) begin
        if (cmd.take_byte) begin
            if (pos_reg < POS_W'(MAX_PACKET_BYTES)) begin
                if (pos_reg == POS_W'(0)) begin
                    flags_reg <= in_item.data_byte;
                    rev_reg   <= '0;
                end else if (pos_reg == POS_W'(2)) begin
                    power_reg[7:0] <= in_item.data_byte;
                end else if (pos_reg == POS_W'(3)) begin
                    power_reg[15:8] <= in_item.data_byte;
                end else if (pos_reg > POS_W'(3) && in_range) begin
                    if (has_crank) begin
                        case (idx)
                            NEED_W'(0): rev_reg[7:0]   <= in_item.data_byte;
                            NEED_W'(1): rev_reg[15:8]  <= in_item.data_byte;
                            NEED_W'(2): time_reg[7:0]  <= in_item.data_byte;
                            NEED_W'(3): time_reg[15:8] <= in_item.data_byte;
                            default:    time_reg       <= time_reg;
                        endcase
                    end else if (has_wheel) begin
                        case (idx)
                            NEED_W'(0): rev_reg[7:0]   <= in_item.data_byte;
                            NEED_W'(1): rev_reg[15:8]  <= in_item.data_byte;
                            NEED_W'(2): rev_reg[23:16] <= in_item.data_byte;
                            NEED_W'(3): rev_reg[31:24] <= in_item.data_byte;
                            NEED_W'(4): time_reg[7:0]  <= in_item.data_byte;
                            NEED_W'(5): time_reg[15:8] <= in_item.data_byte;
                            default:    time_reg       <= time_reg;
                        endcase
                    end
                end
            end
            if (in_item.last_byte) begin
                len_reg <= pos_inc;
                now_reg <= in_item.now_ms;
            end
        end

        if (cmd.load_diff) begin
            dr_reg <= rev_reg - prev_revs_reg;
            dt_reg <= time_reg - prev_time_reg;
        end

        // Wheel and crank both reduce to dr * 61440 / dt, and 61440 = 15 * 4096.
        if (cmd.load_mul) begin
            prod_reg <= {dr_reg, 4'd0} - {4'd0, dr_reg};
        end

        if (cmd.div_start) begin
            rem_reg  <= {prod_reg[11:0], 4'd0};
            quot_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= ge ? 16'(rem2 - {1'b0, dt_reg}) : rem2[15:0];
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
        end

        if (cmd.commit) begin
            if (pkt_error) begin
                out_reg.power_watts  <= '0;
                out_reg.cadence_rpm  <= cadence_reg;
                out_reg.revolutions  <= '0;
                out_reg.event_time   <= '0;
                out_reg.revs_present <= 1'b0;
                out_reg.packet_error <= 1'b1;
            end else begin
                out_reg.power_watts  <= power_reg;
                out_reg.cadence_rpm  <= cadence_next;
                out_reg.revolutions  <= has_revs ? rev_reg : '0;
                out_reg.event_time   <= has_revs ? time_reg : '0;
                out_reg.revs_present <= has_revs;
                out_reg.packet_error <= 1'b0;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule
